// ----- rtl/core/frh_pkg.sv -----
// ----------------------------------------------------------------------------
// frh_pkg
// Shared widths, mode codes and defaults for the frame rate histogram.
// ----------------------------------------------------------------------------
package frh_pkg;

    // Field widths
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 32;
    localparam int TOTAL_W = 64;
    localparam int BIN_W   = 32;
    localparam int INDEX_W = 8;

    // Bin index zero-extended to this width covers the largest bin count
    localparam int IDX_EXT_W = 13;

    // Default top bin
    localparam int DEF_MAX_RATE = 255;

    // Item kinds
    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Frame event outcome toward the histogram
    typedef struct packed {
        logic close;    // second has ended: bump one bin
        logic frame;    // item is a frame event
    } t_frm_evt;

endpackage

// ----- rtl/core/frh_bin_ram.sv -----
// ----------------------------------------------------------------------------
// frh_bin_ram
// Histogram bin memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module frh_bin_ram
    import frh_pkg::*;
#(
    parameter int MAX_RATE = DEF_MAX_RATE,
    localparam int DEPTH  = MAX_RATE + 1,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [BIN_W-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [BIN_W-1:0]  o_rd_data
);

    logic [BIN_W-1:0] r_mem [DEPTH];
    logic [BIN_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/frh_scalar.sv -----
// ----------------------------------------------------------------------------
// frh_scalar
// Per-second frame counter, running total and the saturated bin slot.
// ----------------------------------------------------------------------------
module frh_scalar
    import frh_pkg::*;
#(
    parameter int MAX_RATE = DEF_MAX_RATE,
    localparam int ADDR_W = $clog2(MAX_RATE + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_upd_en,
    input  logic               i_mode,
    input  logic [STAMP_W-1:0] i_second_stamp,
    output logic [TOTAL_W-1:0] o_total,
    output logic [COUNT_W-1:0] o_count,
    output t_frm_evt           o_evt,
    output logic [ADDR_W-1:0]  o_slot
);

    logic [STAMP_W-1:0] r_last;
    logic [COUNT_W-1:0] r_count;
    logic [TOTAL_W-1:0] r_total;
    logic [STAMP_W-1:0] n_last;
    logic [COUNT_W-1:0] n_count;
    logic [TOTAL_W-1:0] n_total;
    logic               frame;
    logic               close;

    assign frame = (i_mode == MODE_FRAME);
    assign close = frame && (i_second_stamp != r_last);

    // Next state for a frame event; reads leave everything as is
    always_comb begin
        n_last  = r_last;
        n_count = r_count;
        n_total = r_total;
        if (frame) begin
            if (close) begin
                n_total = r_total + TOTAL_W'(r_count);
                n_count = COUNT_W'(1);
                n_last  = i_second_stamp;
            end else begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_count <= '0;
            r_total <= '0;
        end else if (i_upd_en) begin
            r_last  <= n_last;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    // Saturate the ended second's count at the top bin
    assign o_slot = (r_count > COUNT_W'(MAX_RATE)) ? ADDR_W'(MAX_RATE)
                                                  : r_count[ADDR_W-1:0];

    assign o_total     = n_total;
    assign o_count     = n_count;
    assign o_evt.close = close;
    assign o_evt.frame = frame;

endmodule

// ----- rtl/core/frame_rate_histogram.sv -----
// ----------------------------------------------------------------------------
// frame_rate_histogram
// Frames-per-second histogram with a bin read-back path.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries a frame event (i_mode = 0,
//   i_second_stamp) or a bin read (i_mode = 1, i_bin_index). Each transfer
//   gives exactly one result on the output channel (o_valid / i_stall):
//   running total, frames in the current second, and the bin count (zero
//   for frame events and for bins above MAX_RATE).
//   The result passes through the middle stage and the output register to
//   o_valid. Throughput is one item per cycle while o_stall is low: the
//   scalar counters update at the input transfer, the bin memory is read in
//   that same cycle and written back from the middle stage, with a bypass
//   register covering a read that meets that write.
//   After reset the bin memory is cleared one entry per cycle, and o_stall stays high for that sweep.
//   When the receiver stalls, the output register holds its result, the
//   middle stage fills, and then o_stall rises until the output drains.
// ----------------------------------------------------------------------------
module frame_rate_histogram
    import frh_pkg::*;
#(
    parameter int MAX_RATE = DEF_MAX_RATE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [STAMP_W-1:0] i_second_stamp,
    input  logic [INDEX_W-1:0] i_bin_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [TOTAL_W-1:0] o_frame_total,
    output logic [COUNT_W-1:0] o_frames_in_second,
    output logic [BIN_W-1:0]   o_bin_count
);

    localparam int ADDR_W = $clog2(MAX_RATE + 1);

    // Handshake and stage control
    logic in_acc;
    logic s1_adv;

    // Scalar unit results
    logic [TOTAL_W-1:0] sc_total;
    logic [COUNT_W-1:0] sc_count;
    t_frm_evt           sc_evt;
    logic [ADDR_W-1:0]  sc_slot;

    // Read address for the incoming item
    logic [IDX_EXT_W-1:0] idx_ext;
    logic                 idx_oob;
    logic [ADDR_W-1:0]    rd_addr;

    // Memory ports
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [BIN_W-1:0]  ram_wr_data;
    logic [BIN_W-1:0]  ram_rd_data;

    // Clearing sweep
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Middle stage
    logic               r_s1_valid;
    logic               r_s1_mode;
    logic               r_s1_inc;
    logic               r_s1_oob;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [TOTAL_W-1:0] r_s1_total;
    logic [COUNT_W-1:0] r_s1_count;
    logic               r_byp_valid;
    logic [BIN_W-1:0]   r_byp_data;
    logic [BIN_W-1:0]   s1_bin;
    logic               s1_wr_en;

    // Output register
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_total;
    logic [COUNT_W-1:0] r_out_count;
    logic [BIN_W-1:0]   r_out_bin;

    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_clr_busy || (r_s1_valid && !s1_adv);
    assign in_acc  = i_valid && !o_stall;

    frh_scalar #(
        .MAX_RATE (MAX_RATE)
    ) u_scalar (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_upd_en       (in_acc),
        .i_mode         (i_mode),
        .i_second_stamp (i_second_stamp),
        .o_total        (sc_total),
        .o_count        (sc_count),
        .o_evt          (sc_evt),
        .o_slot         (sc_slot)
    );

    // Pick the bin to read: requested bin or the slot to bump
    assign idx_ext = IDX_EXT_W'(i_bin_index);
    assign idx_oob = idx_ext > IDX_EXT_W'(MAX_RATE);
    assign rd_addr = sc_evt.frame ? sc_slot : idx_ext[ADDR_W-1:0];

    // Bin value seen by the middle stage, with the write bypass
    assign s1_bin   = r_byp_valid ? r_byp_data : ram_rd_data;
    assign s1_wr_en = r_s1_valid && r_s1_inc && s1_adv;

    // Memory write: clearing sweep or the increment write-back
    always_comb begin
        if (r_clr_busy) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = s1_wr_en;
            ram_wr_addr = r_s1_addr;
            ram_wr_data = s1_bin + BIN_W'(1);
        end
    end

    frh_bin_ram #(
        .MAX_RATE (MAX_RATE)
    ) u_bin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Sweep the memory to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(MAX_RATE)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Middle stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid  <= 1'b1;
                r_byp_valid <= s1_wr_en && (r_s1_addr == rd_addr);
            end else if (s1_adv) begin
                r_s1_valid  <= 1'b0;
            end
        end
    end

    // Middle stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode  <= i_mode;
            r_s1_inc   <= sc_evt.close;
            r_s1_oob   <= idx_oob;
            r_s1_addr  <= rd_addr;
            r_s1_total <= sc_total;
            r_s1_count <= sc_count;
            r_byp_data <= ram_wr_data;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_total <= r_s1_total;
            r_out_count <= r_s1_count;
            r_out_bin   <= (r_s1_mode == MODE_READ && !r_s1_oob) ? s1_bin : '0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_frame_total      = r_out_total;
    assign o_frames_in_second = r_out_count;
    assign o_bin_count        = r_out_bin;

    // Checks
    a_clr_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_acc)
        else $error("item transferred during memory clear");

    a_close_bumps_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && sc_evt.close) |=> (r_s1_valid && r_s1_inc))
        else $error("ended second did not reach the bin update stage");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_mode == MODE_READ) |-> !r_s1_inc)
        else $error("bin read item marked for increment");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (ram_wr_addr <= ADDR_W'(MAX_RATE)))
        else $error("bin write beyond top bin");

endmodule
